// ===== rtl/ses_pkg.sv =====
`timescale 1ns / 1ps
package ses_pkg;
  localparam int unsigned CountW = 16;
  localparam int unsigned TimeW = 32;
  localparam int unsigned SpeedW = 32;
  localparam int unsigned TprW = 16;
  localparam int unsigned RateW = 64;
  localparam logic [TprW-1:0] TprReset = 16'd1024;
  localparam logic [20:0] UsPerSec = 21'd1000000;

  typedef enum logic [2:0] {
    BkIdle,
    BkRead,
    BkMul,
    BkDiv,
    BkAcc,
    BkFinal,
    BkFdiv,
    BkOut
  } bk_state_e;

  typedef struct packed {
    logic [CountW-1:0] count;
    logic [TimeW-1:0] time_us;
  } sample_t;
endpackage

// ===== rtl/ses_if.sv =====
`timescale 1ns / 1ps
interface ses_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] encoder_count;
  logic [31:0] time_us;
  modport source(output valid, encoder_count, time_us, input ready);
  modport sink(input valid, encoder_count, time_us, output ready);
endinterface

interface ses_out_if;
  logic valid;
  logic ready;
  logic [31:0] speed_rps;
  modport source(output valid, speed_rps, input ready);
  modport sink(input valid, speed_rps, output ready);
endinterface

// ===== rtl/ses_front.sv =====
`timescale 1ns / 1ps
module ses_front (
  input  logic clk_i,
  input  logic rst_ni,
  ses_in_if.sink in_if,
  output logic q_valid_o,
  input  logic q_ready_i,
  output ses_pkg::sample_t q_data_o
);
  import ses_pkg::*;

  logic    full_q, full_d;
  sample_t data_q, data_d;

  assign in_if.ready = !full_q;
  assign q_valid_o = full_q;
  assign q_data_o = data_q;

  always_comb begin
    full_d = full_q;
    data_d = data_q;
    if (full_q && q_ready_i) full_d = 1'b0;
    if (in_if.valid && !full_q) begin
      full_d = 1'b1;
      data_d = '{count: in_if.encoder_count, time_us: in_if.time_us};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) full_q <= 1'b0;
    else full_q <= full_d;
  end

  always_ff @(posedge clk_i) data_q <= data_d;
endmodule

// ===== rtl/ses_divider.sv =====
`timescale 1ns / 1ps
module ses_divider (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output logic busy_o,
  output logic [63:0] quo_o
);
  logic [63:0] rem_q, rem_d, quo_q, quo_d, den_q;
  logic [6:0]  cnt_q, cnt_d;
  logic [64:0] trial;

  assign busy_o = cnt_q != 7'd0;
  assign quo_o = quo_q;

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    trial = {rem_q, quo_q[63]} - {1'b0, den_q};
    if (start_i) begin
      rem_d = '0;
      quo_d = num_i;
      cnt_d = 7'd64;
    end else if (cnt_q != 7'd0) begin
      cnt_d = cnt_q - 7'd1;
      if (!trial[64]) begin
        rem_d = trial[63:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = {rem_q[62:0], quo_q[63]};
        quo_d = {quo_q[62:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else cnt_q <= cnt_d;
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) den_q <= den_i;
  end
endmodule

// ===== rtl/ses_back.sv =====
`timescale 1ns / 1ps
module ses_back #(
  parameter int unsigned DEPTH = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_valid_i,
  output logic q_ready_o,
  input  ses_pkg::sample_t q_data_i,
  input  logic [15:0] tpr_i,
  ses_out_if.source out_if
);
  import ses_pkg::*;
  localparam int unsigned SlotW = $clog2(DEPTH);
  localparam logic [SlotW-1:0] LastSlot = SlotW'(DEPTH - 1);
  localparam logic [SlotW-1:0] WarmSlot = SlotW'(DEPTH - 2);
  localparam logic [6:0] NumIv = 7'(DEPTH - 1);

  bk_state_e state_q, state_d;
  logic [CountW-1:0] cring [DEPTH];
  logic [TimeW-1:0]  tring [DEPTH];
  logic [SlotW-1:0] wslot_q, wslot_d, a_q, a_d, b_sl, wr_addr;
  logic warm_q, warm_d, wr_en;
  logic [CountW-1:0] wr_c, ca_q, cb_q, cp_c_q;
  logic [TimeW-1:0]  wr_t, ta_q, tb_q, cp_t_q;
  logic [6:0] iv_q, iv_d;
  logic [16:0] dc;
  logic [31:0] dt;
  logic [16:0] mag_q;
  logic neg_q;
  logic [31:0] dt_q;
  logic [52:0] prod;
  logic signed [RateW-1:0] sum_q, sum_d;
  logic out_v_q, out_v_d;
  logic [SpeedW-1:0] out_q, out_d;
  logic div_start, div_busy;
  logic [63:0] div_num, div_den, div_quo, sum_mag;
  logic [15:0] tpr_eff;

  assign b_sl = (a_q == LastSlot) ? '0 : a_q + 1'b1;
  assign dc = {cb_q[15], cb_q} - {ca_q[15], ca_q};
  assign dt = tb_q - ta_q;
  assign prod = 53'(mag_q) * 53'(UsPerSec);
  assign sum_mag = sum_q[RateW-1] ? 64'(-sum_q) : 64'(sum_q);
  assign tpr_eff = (tpr_i == '0) ? 16'd1 : tpr_i;

  ses_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .busy_o(div_busy), .quo_o(div_quo)
  );

  assign out_if.valid = out_v_q;
  assign out_if.speed_rps = out_q;

  always_comb begin
    state_d = state_q;
    wslot_d = wslot_q;
    warm_d = warm_q;
    a_d = a_q;
    iv_d = iv_q;
    sum_d = sum_q;
    out_v_d = out_v_q && !out_if.ready;
    out_d = out_q;
    q_ready_o = 1'b0;
    wr_en = 1'b0;
    wr_addr = wslot_q;
    wr_c = q_data_i.count;
    wr_t = q_data_i.time_us;
    div_start = 1'b0;
    div_num = 64'(prod) << 16;
    div_den = 64'(dt_q);
    unique case (state_q)
      BkIdle: begin
        if (q_valid_i && !out_v_q) begin
          q_ready_o = 1'b1;
          wr_en = 1'b1;
          wslot_d = (wslot_q == LastSlot) ? '0 : wslot_q + 1'b1;
          if (!warm_q) begin
            if (wslot_q == WarmSlot) begin
              warm_d = 1'b1;
              state_d = BkFinal;
            end
          end else begin
            a_d = wslot_d;
            iv_d = '0;
            sum_d = '0;
            state_d = BkRead;
          end
        end
      end
      BkFinal: begin
        wr_en = 1'b1;
        wr_addr = LastSlot;
        wr_t = cp_t_q;
        wr_c = cp_c_q;
        wslot_d = '0;
        a_d = '0;
        iv_d = '0;
        sum_d = '0;
        state_d = BkRead;
      end
      BkRead: state_d = BkMul;
      BkMul: state_d = BkDiv;
      BkDiv: begin
        if (dt_q == '0) state_d = BkAcc;
        else begin
          div_start = 1'b1;
          state_d = BkAcc;
        end
      end
      BkAcc: begin
        if (!div_busy) begin
          if (dt_q != '0) sum_d = neg_q ? sum_q - $signed(div_quo) : sum_q + $signed(div_quo);
          a_d = b_sl;
          iv_d = iv_q + 7'd1;
          state_d = (iv_q + 7'd1 == NumIv) ? BkFdiv : BkRead;
          if (iv_q + 7'd1 == NumIv) begin
            div_start = 1'b1;
            div_num = (dt_q != '0) ? (neg_q ? 64'(-(sum_q - $signed(div_quo))) :
                                     64'(sum_q + $signed(div_quo))) : sum_mag;
            div_num = (sum_d[RateW-1]) ? 64'(-sum_d) : 64'(sum_d);
            div_den = 64'(NumIv) * 64'(tpr_eff);
          end
        end
      end
      BkFdiv: begin
        if (!div_busy) state_d = BkOut;
      end
      BkOut: begin
        out_v_d = 1'b1;
        out_d = (div_quo[63:32] != '0) ? '1 : div_quo[31:0];
        state_d = BkIdle;
      end
      default: state_d = BkIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BkIdle;
      wslot_q <= '0;
      warm_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wslot_q <= wslot_d;
      warm_q <= warm_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      cring[wr_addr] <= wr_c;
      tring[wr_addr] <= wr_t;
    end
    if (q_ready_o) begin
      cp_c_q <= q_data_i.count;
      cp_t_q <= q_data_i.time_us + 32'd1;
    end
    ca_q <= cring[a_q];
    ta_q <= tring[a_q];
    cb_q <= cring[b_sl];
    tb_q <= tring[b_sl];
    mag_q <= dc[16] ? 17'(-dc) : dc;
    neg_q <= dc[16];
    dt_q <= dt;
    a_q <= a_d;
    iv_q <= iv_d;
    sum_q <= sum_d;
    out_q <= out_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BkOut |=> out_v_q)
    else $error("result not presented");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_if.ready |=> out_v_q && $stable(out_q))
    else $error("stalled result changed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != BkIdle |-> !q_ready_o)
    else $error("accept while busy");
endmodule

// ===== rtl/encoder_speed_estimator_core.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Payload
// in_if     in   encoder_count[15:0] signed, time_us[31:0]
// out_if    out  speed_rps[31:0] unsigned Q16.16
// apb       in   tick scale register at address 0
// Each interval is loaded through the Read, Mul and Div states, then divided in the shared 64-step
// divider, which is skipped when the interval is zero. A final scaling divide follows, and a warm
// item holds the back end from its accept until its result has been taken.
// Reset is asynchronous and active low; the ring contents are not cleared.
// A one-entry queue decouples input from the back end; a result waits in its register.
module encoder_speed_estimator_core #(
  parameter int unsigned DEPTH = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  ses_in_if.sink in_if,
  ses_out_if.source out_if,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import ses_pkg::*;

  logic [TprW-1:0] tpr_q;
  logic q_valid, q_ready;
  sample_t q_data;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? 32'(tpr_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tpr_q <= TprReset;
    else if (psel && penable && pwrite && paddr == 2'd0) tpr_q <= pwdata[TprW-1:0];
  end

  ses_front u_front (
    .clk_i, .rst_ni, .in_if, .q_valid_o(q_valid), .q_ready_i(q_ready), .q_data_o(q_data)
  );

  ses_back #(.DEPTH(DEPTH)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_ready_o(q_ready), .q_data_i(q_data),
    .tpr_i(tpr_q), .out_if
  );
endmodule

// ===== bench/encoder_speed_estimator_core_tb.sv =====
`timescale 1ns / 1ps
module encoder_speed_estimator_core_tb;
  import ses_pkg::*;

  localparam int unsigned Depth = 8;
  localparam int unsigned SettleCycles = 800;
  localparam int unsigned IdleLimit = 20000;

  typedef struct {
    logic [CountW-1:0] count;
    logic [TimeW-1:0] stamp;
  } enc_sample_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  ses_in_if in_if ();
  ses_out_if out_if ();

  encoder_speed_estimator_core #(.DEPTH(Depth)) DUT (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_if(in_if),
    .out_if(out_if),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  enc_sample_t pending_samples[$];
  logic [SpeedW-1:0] expected_speeds[$];
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  bit sample_taken = 0;
  bit no_idling = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;

  logic [CountW-1:0] ring_count[Depth];
  logic [TimeW-1:0] ring_stamp[Depth];
  int unsigned next_slot = 0;
  bit warmed = 0;
  logic [TprW-1:0] tick_scale = TprReset;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idling || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  function automatic void store_sample(logic [CountW-1:0] c, logic [TimeW-1:0] t);
    ring_count[next_slot] = c;
    ring_stamp[next_slot] = t;
    next_slot = (next_slot + 1 >= Depth) ? 0 : next_slot + 1;
  endfunction

  function automatic void predict_speed(logic [CountW-1:0] c, logic [TimeW-1:0] t);
    longint sum;
    longint unsigned mag;
    longint unsigned den;
    longint unsigned q;
    longint dc;
    logic [TimeW-1:0] dt;
    int unsigned a;
    int unsigned b;
    store_sample(c, t);
    if (!warmed) begin
      if (next_slot != Depth - 1) return;
      warmed = 1;
      store_sample(c, t + 1);
    end
    sum = 0;
    a = next_slot;
    for (int i = 0; i < Depth - 1; i++) begin
      b = (a + 1 >= Depth) ? 0 : a + 1;
      dc = longint'($signed(ring_count[b])) - longint'($signed(ring_count[a]));
      dt = ring_stamp[b] - ring_stamp[a];
      if (dt != 0) begin
        mag = (dc < 0) ? longint'(-dc) : longint'(dc);
        q = (mag * 64'd1000000 * 64'd65536) / longint'({32'd0, dt});
        sum += (dc < 0) ? -longint'(q) : longint'(q);
      end
      a = b;
    end
    mag = (sum < 0) ? -sum : sum;
    den = (Depth - 1) * ((tick_scale == 0) ? 64'd1 : longint'({48'd0, tick_scale}));
    q = mag / den;
    expected_speeds.push_back((q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0]);
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      idle_cycles++;
      if (in_if.valid && in_if.ready) begin
        sample_taken = 1;
        idle_cycles = 0;
        predict_speed(in_if.encoder_count, in_if.time_us);
      end
      if (out_if.valid && out_if.ready) begin
        idle_cycles = 0;
        if (expected_speeds.size() == 0) begin
          $error("speed_rps: no result expected, actual %0h", out_if.speed_rps);
          error_count++;
        end else begin
          if (out_if.speed_rps !== expected_speeds[0]) begin
            $error("speed_rps: expected %0h, actual %0h", expected_speeds[0],
                   out_if.speed_rps);
            error_count++;
          end
          void'(expected_speeds.pop_front());
        end
      end
      if (idle_cycles >= IdleLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    enc_sample_t s;
    if (!(in_if.valid && !sample_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_if.valid <= 0;
      end else if (pending_samples.size() > 0) begin
        s = pending_samples.pop_front();
        in_if.valid <= 1;
        in_if.encoder_count <= s.count;
        in_if.time_us <= s.stamp;
        send_gap = pick_gap();
      end else begin
        in_if.valid <= 0;
      end
    end
    sample_taken = 0;
    if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 0;
    end else begin
      stall_left = pick_gap();
      out_if.ready <= (stall_left == 0);
    end
  end

  task automatic push_sample(logic [CountW-1:0] c, logic [TimeW-1:0] t);
    enc_sample_t s;
    s.count = c;
    s.stamp = t;
    pending_samples.push_back(s);
  endtask

  task automatic push_random(int unsigned n);
    logic [CountW-1:0] c;
    logic [TimeW-1:0] t;
    int unsigned r;
    c = 16'($urandom());
    t = $urandom();
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        c = 16'($urandom());
        t = $urandom();
      end else begin
        if (r < 70) t += $urandom_range(1500, 2500);
        else if (r < 85) t += $urandom_range(1, 20);
        else if (r < 92) t += 0;
        else t += $urandom();
        if ($urandom_range(0, 9) == 0) c = 16'($urandom());
        else c += 16'($signed($urandom_range(0, 400)) - 200);
      end
      push_sample(c, t);
    end
  endtask

  task automatic wait_drained();
    while (pending_samples.size() > 0 || in_if.valid || expected_speeds.size() > 0)
      @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_tpr(logic [TprW-1:0] value);
    @(negedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= 2'd0;
    pwdata <= {16'd0, value};
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    tick_scale = value;
  endtask

  initial begin
    logic [TprW-1:0] settings[6];
    settings = '{16'd1, 16'd65535, 16'd0, 16'd1024, 16'd7, 16'd300};
    rst_n = 0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = 0;
    pwdata = 0;
    in_if.valid = 0;
    in_if.encoder_count = 0;
    in_if.time_us = 0;
    out_if.ready = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    for (int i = 0; i < 7; i++) push_sample(16'(i * 10), 32'(1000 + 2000 * i));
    push_sample(16'h7FFF, 32'd13001);
    push_sample(16'h8000, 32'd13002);
    push_sample(16'h7FFF, 32'd13003);
    push_sample(16'h7FFF, 32'd13003);
    push_sample(16'h8000, 32'd13003);
    push_sample(16'h0000, 32'hFFFF_FFFE);
    push_sample(16'h0010, 32'hFFFF_FFFF);
    push_sample(16'h0020, 32'h0000_0001);
    push_sample(16'hFFFF, 32'h0000_07D1);
    push_sample(16'h0000, 32'h0000_0FA1);
    push_sample(16'h8000, 32'h8000_0000);
    push_sample(16'h7FFF, 32'h8000_0000);
    push_sample(16'h0000, 32'h0000_0000);
    wait_drained();

    foreach (settings[p]) begin
      write_tpr(settings[p]);
      if (p == 2) write_tpr(16'($urandom_range(1, 65535)));
      no_idling = (p % 3 == 1);
      push_random(155);
      wait_drained();
    end

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/ses_pkg.sv
rtl/ses_if.sv
rtl/ses_front.sv
rtl/ses_divider.sv
rtl/ses_back.sv
rtl/encoder_speed_estimator_core.sv
bench/encoder_speed_estimator_core_tb.sv
